### rtl/core/agm_pkg.sv
package agm_pkg;

  // Field widths fixed by the interface
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned REV_W  = 16;
  localparam int unsigned CFG_W  = 16;

  localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_PULSE  = 2'd0,
    CMD_WINDOW = 2'd1,
    CMD_GUST   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_WINDOW   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_UPDATE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

endpackage

### rtl/core/agm_ring.sv
module agm_ring #(
  parameter int unsigned DEPTH  = 20,
  parameter int unsigned ADDR_W = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [agm_pkg::REV_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [agm_pkg::REV_W-1:0]  rd_data
);
  import agm_pkg::*;

  logic [REV_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [REV_W-1:0] rd_q;
  logic             rd_vld;

  // Slot storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Per-slot valid bits; an unwritten slot reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

### rtl/core/anemometer_gust_meter.sv
// Anemometer gust meter. Each input beat carries a command (pulse edge,
// window check, gust reset) and a 32-bit millisecond timestamp; all elapsed
// times are taken modulo 2^32. A pulse counts only if at least debounce_ms
// have passed since the last counted pulse; counted pulses bump pulse_count
// and keep the shortest inter-pulse interval. A window check at least
// window_ms after the previous sample stores the pulses gained since then,
// clipped to 65535, into a ring of RING_DEPTH slots. A gust reset rewinds
// the ring position and the gained-count base but keeps the slots. Every
// input beat returns exactly one result beat with the state after the item.
// Steps per item: the block forms the timestamp differences, then updates
// state, then a single compare unit walks the ring one slot per cycle to
// find the peak, behind a registered ring read. in_ready is high only while
// the block is idle, so a new item is taken only after the last one is
// through; the result sits in an output register, so a new item can be
// taken while it waits. The ring's slots come up as zero after reset
// through per-slot valid bits, so there is no clearing pass. Config writes
// land at the next edge in any state; make them only while no item is in
// flight.
module anemometer_gust_meter #(
  parameter int unsigned RING_DEPTH = 20
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [agm_pkg::CFG_W-1:0]    cfg_data,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic [agm_pkg::TIME_W-1:0]   time_ms,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [agm_pkg::CNT_W-1:0]    pulse_count,
  output logic [agm_pkg::TIME_W-1:0]   shortest_interval,
  output logic [agm_pkg::REV_W-1:0]    gust_peak,
  output logic                         pulse_accepted,
  output logic                         sample_taken
);
  import agm_pkg::*;

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  state_t state, state_next;

  // Config registers
  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] window_ms;

  // Captured input beat
  cmd_t              cmd_q;
  logic [TIME_W-1:0] now_q;

  // Meter state
  logic [TIME_W-1:0] last_pulse_time;
  logic [TIME_W-1:0] shortest_gap;
  logic [CNT_W-1:0]  pulse_total;
  logic [CNT_W-1:0]  previous_total;
  logic [TIME_W-1:0] last_sample_time;
  logic [IDX_W-1:0]  ring_index;

  // Arithmetic stage registers
  logic [TIME_W-1:0] diff;
  logic [CNT_W-1:0]  gained;
  logic              acc_flag;
  logic              smp_flag;

  // Scan unit
  logic [IDX_W-1:0]  scan_cnt;
  logic              scan_live;
  logic [REV_W-1:0]  peak;
  logic [REV_W-1:0]  rd_data;

  // Ring write
  logic              ring_we;
  logic [REV_W-1:0]  ring_wdata;

  // FSM control
  logic              take_in;
  logic              out_free;
  logic              load_out;

  assign out_free = !out_valid || out_ready;
  assign take_in  = in_valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_SCAN;
      ST_SCAN:   if (scan_cnt == LAST_IDX) state_next = ST_LAST;
      ST_LAST:   state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DONE: load_out = out_free;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Config port
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= CFG_W'(10);
      window_ms   <= CFG_W'(3000);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE: debounce_ms <= cfg_data;
        REG_WINDOW:   window_ms   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Capture beat, form differences
  always_ff @(posedge clk) begin
    if (take_in) begin
      cmd_q <= cmd_t'(command);
      now_q <= time_ms;
    end
    if (state == ST_DIFF) begin
      diff   <= (cmd_q == CMD_PULSE) ? now_q - last_pulse_time
                                     : now_q - last_sample_time;
      gained <= pulse_total - previous_total;
    end
  end

  // Saturate gained count for storage
  assign ring_wdata = (|gained[CNT_W-1:REV_W]) ? REV_MAX : gained[REV_W-1:0];
  assign ring_we    = (state == ST_UPDATE) && (cmd_q == CMD_WINDOW) &&
                      (diff >= TIME_W'(window_ms));

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time  <= '0;
      shortest_gap     <= '1;
      pulse_total      <= '0;
      previous_total   <= '0;
      last_sample_time <= '0;
      ring_index       <= '0;
      acc_flag         <= 1'b0;
      smp_flag         <= 1'b0;
    end else if (state == ST_UPDATE) begin
      acc_flag <= 1'b0;
      smp_flag <= 1'b0;
      case (cmd_q)
        CMD_PULSE: begin
          if (diff >= TIME_W'(debounce_ms)) begin
            if (diff < shortest_gap) begin
              shortest_gap <= diff;
            end
            pulse_total     <= pulse_total + CNT_W'(1);
            last_pulse_time <= now_q;
            acc_flag        <= 1'b1;
          end
        end
        CMD_WINDOW: begin
          if (ring_we) begin
            last_sample_time <= now_q;
            previous_total   <= pulse_total;
            ring_index       <= (ring_index == LAST_IDX) ? '0
                                                         : ring_index + IDX_W'(1);
            smp_flag         <= 1'b1;
          end
        end
        CMD_GUST: begin
          ring_index     <= '0;
          previous_total <= '0;
        end
        default: ;
      endcase
    end
  end

  agm_ring #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ring_we),
    .wr_addr (ring_index),
    .wr_data (ring_wdata),
    .rd_addr (scan_cnt),
    .rd_data (rd_data)
  );

  // Peak scan: one slot per cycle, read data lands in the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt  <= '0;
      scan_live <= 1'b0;
    end else begin
      scan_live <= (state == ST_SCAN);
      if (state == ST_SCAN) begin
        scan_cnt <= (scan_cnt == LAST_IDX) ? '0 : scan_cnt + IDX_W'(1);
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      peak <= '0;
    end else if (scan_live && (rd_data > peak)) begin
      peak <= rd_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pulse_count       <= pulse_total;
      shortest_interval <= shortest_gap;
      gust_peak         <= peak;
      pulse_accepted    <= acc_flag;
      sample_taken      <= smp_flag;
    end
  end

endmodule

### test/anemometer_gust_meter_test.sv
module anemometer_gust_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import agm_pkg::*;

  localparam int RING_SLOTS   = 20;
  localparam int NO_BEAT_MAX  = 2000;   // watchdog: cycles with no beat on either side
  localparam int LONG_HOLD    = 300;    // receiver hold-off used to back up the block
  localparam int SETTLE       = RING_SLOTS + 10;
  localparam int PHASE_ITEMS  = 116;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] stamp;
  } meter_item_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] shortest;
    logic [15:0] peak;
    logic        accepted;
    logic        sampled;
  } gust_result_t;

  // DUT inputs, all known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [1:0]  command = CMD_NONE;
  logic [31:0] time_ms = '0;
  logic        out_ready = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [31:0] pulse_count;
  logic [31:0] shortest_interval;
  logic [15:0] gust_peak;
  logic        pulse_accepted;
  logic        sample_taken;

  anemometer_gust_meter dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .time_ms           (time_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .pulse_count       (pulse_count),
    .shortest_interval (shortest_interval),
    .gust_peak         (gust_peak),
    .pulse_accepted    (pulse_accepted),
    .sample_taken      (sample_taken)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Meter shadow: same state as the block, advanced once per input beat
  // ---------------------------------------------------------------------
  logic [15:0] mtr_debounce = 16'd10;
  logic [15:0] mtr_window   = 16'd3000;
  logic [31:0] mtr_last_pulse  = '0;
  logic [31:0] mtr_min_gap     = '1;
  logic [31:0] mtr_total       = '0;
  logic [31:0] mtr_base        = '0;   // pulse total at the last sample
  logic [31:0] mtr_last_sample = '0;
  int          mtr_slot        = 0;
  logic [15:0] mtr_ring [RING_SLOTS];

  // expected result beats, oldest first
  gust_result_t results_due[$];
  // items waiting for the driver
  meter_item_t  pending[$];

  int beats_queued = 0;
  int beats_in     = 0;
  int beats_out    = 0;
  int fail_count   = 0;

  // stimulus-side view of the last sample time, so window checks can be
  // aimed right at the window boundary
  logic [31:0] gen_now = '0;
  logic [31:0] gen_win = '0;

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int stall_req    = 0;
  int stall_seen   = 0;

  function automatic gust_result_t advance_meter(meter_item_t it);
    gust_result_t r;
    logic [31:0]  gap;
    logic [31:0]  gained;
    logic [15:0]  best;
    int           k;
    r = '0;
    case (it.cmd)
      CMD_PULSE: begin
        // elapsed time is a modulo-2^32 difference
        gap = it.stamp - mtr_last_pulse;
        if (gap >= {16'h0, mtr_debounce}) begin
          if (gap < mtr_min_gap) mtr_min_gap = gap;
          mtr_total      = mtr_total + 32'd1;
          mtr_last_pulse = it.stamp;
          r.accepted     = 1'b1;
        end
      end
      CMD_WINDOW: begin
        gap = it.stamp - mtr_last_sample;
        if (gap >= {16'h0, mtr_window}) begin
          gained = mtr_total - mtr_base;
          mtr_ring[mtr_slot] = (gained > {16'h0, REV_MAX}) ? REV_MAX : gained[15:0];
          mtr_slot        = (mtr_slot == RING_SLOTS - 1) ? 0 : mtr_slot + 1;
          mtr_last_sample = it.stamp;
          mtr_base        = mtr_total;
          r.sampled       = 1'b1;
        end
      end
      CMD_GUST: begin
        // rewind only: slots, count, interval and times stay
        mtr_slot = 0;
        mtr_base = '0;
      end
      default: ;
    endcase
    best = mtr_ring[0];
    for (k = 1; k < RING_SLOTS; k++)
      if (mtr_ring[k] > best) best = mtr_ring[k];
    r.count    = mtr_total;
    r.shortest = mtr_min_gap;
    r.peak     = best;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h (result beat %0d)",
             $realtime, what, got, want, beats_out);
    fail_count++;
  endtask

  task automatic compare_result(gust_result_t want);
    if (pulse_count !== want.count)
      report_mismatch("pulse_count", pulse_count, want.count);
    if (shortest_interval !== want.shortest)
      report_mismatch("shortest_interval", shortest_interval, want.shortest);
    if (gust_peak !== want.peak)
      report_mismatch("gust_peak", 32'(gust_peak), 32'(want.peak));
    if (pulse_accepted !== want.accepted)
      report_mismatch("pulse_accepted", 32'(pulse_accepted), 32'(want.accepted));
    if (sample_taken !== want.sampled)
      report_mismatch("sample_taken", 32'(sample_taken), 32'(want.sampled));
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_item(cmd_t cmd, logic [31:0] stamp);
    meter_item_t it;
    it.cmd   = cmd;
    it.stamp = stamp;
    pending.push_back(it);
    beats_queued++;
    if (cmd == CMD_WINDOW && (stamp - gen_win) >= {16'h0, mtr_window})
      gen_win = stamp;
  endfunction

  // Random traffic for one setting: mostly pulse trains spaced around the
  // debounce time plus window checks, half of them aimed at the window boundary;
  // a small share of gust resets, unused commands and fully random beats.
  task automatic fill_phase(int n);
    logic [31:0] deb;
    logic [31:0] win;
    logic [31:0] d;
    logic [31:0] target;
    int          r;
    deb = {16'h0, mtr_debounce};
    win = {16'h0, mtr_window};
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 63) begin
        r = $urandom_range(0, 99);
        if (r < 70)      d = deb + $urandom_range(0, deb / 2 + 3);
        else if (r < 85) d = $urandom_range(0, deb);
        else if (r < 93) d = (deb == 0) ? 32'd0 : deb - 32'd1;
        else             d = deb;
        gen_now = gen_now + d;
        queue_item(CMD_PULSE, gen_now);
      end else if (r < 85) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_item(CMD_WINDOW, gen_now + $urandom_range(0, 3));
        end else begin
          // one ms short, exactly on, or one ms past the boundary
          target = gen_win + win + $urandom_range(0, 2) - 32'd1;
          if ($signed(target - gen_now) >= 0) gen_now = target;
          queue_item(CMD_WINDOW, gen_now);
        end
      end else if (r < 87) begin
        queue_item(CMD_GUST, gen_now);
      end else if (r < 89) begin
        queue_item(CMD_NONE, $urandom);
      end else begin
        queue_item(cmd_t'($urandom_range(0, 3)), $urandom);
      end
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DEBOUNCE: mtr_debounce = val;
      REG_WINDOW:   mtr_window   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every queued item taken and every result back, then let the block settle
  task automatic wait_drained();
    while (!(beats_in == beats_queued && results_due.size() == 0))
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers pending items, predicts each one as its beat is taken
  // ---------------------------------------------------------------------
  meter_item_t cur_item;
  int          send_wait = 0;
  bit          in_fire;

  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        results_due.push_back(advance_meter(cur_item));
        beats_in++;
        if (send_idle_on) send_wait = rand_gap();
      end
      if (in_valid && !in_fire) begin
        // hold payload until taken
      end else if (send_wait != 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        cur_item = pending.pop_front();
        command  <= cur_item.cmd;
        time_ms  <= cur_item.stamp;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks result beats in order, drives out_ready
  // ---------------------------------------------------------------------
  int hold_left = 0;
  int recv_wait = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (results_due.size() == 0)
          report_mismatch("result with nothing pending", pulse_count, '0);
        else
          compare_result(results_due.pop_front());
      end
      // long hold-off, counted here, so the block backs up its input
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_idle_on && $urandom_range(0, 3) == 0) recv_wait = rand_gap();
      end
    end
  end

  // Watchdog: too long without a beat on either channel
  int no_beat = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      no_beat = 0;
    end else begin
      no_beat++;
      if (no_beat == NO_BEAT_MAX) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 NO_BEAT_MAX, results_due.size());
        $display("[anemometer_gust_meter] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed beats at reset settings, then several settings
  // ---------------------------------------------------------------------
  logic [15:0] set_deb;
  logic [15:0] set_win;

  initial begin
    for (int k = 0; k < RING_SLOTS; k++) mtr_ring[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: debounce 10, window 3000.
    queue_item(CMD_PULSE,  32'd0);           // first pulse measured against time 0
    queue_item(CMD_PULSE,  32'd9);           // one short of debounce
    queue_item(CMD_PULSE,  32'd10);          // exactly debounce
    queue_item(CMD_PULSE,  32'd19);
    queue_item(CMD_PULSE,  32'd20);
    queue_item(CMD_PULSE,  32'd100);
    queue_item(CMD_WINDOW, 32'd2999);        // one short of window
    queue_item(CMD_WINDOW, 32'd3000);        // exactly window
    queue_item(CMD_NONE,   32'hFFFF_FFFF);   // unused command
    queue_item(CMD_PULSE,  32'd3005);
    queue_item(CMD_GUST,   32'd3006);        // rewind ring and base
    queue_item(CMD_WINDOW, 32'd3007);
    queue_item(CMD_WINDOW, 32'd6000);        // gained counted from zero base
    queue_item(CMD_PULSE,  32'hFFFF_FFF0);
    queue_item(CMD_PULSE,  32'h0000_0003);   // interval across the wrap
    queue_item(CMD_PULSE,  32'h0000_000C);   // wrapped, under debounce
    queue_item(CMD_WINDOW, 32'h0000_0000);   // time went back: huge elapsed
    queue_item(CMD_WINDOW, 32'hFFFF_FFFF);
    queue_item(CMD_NONE,   32'h0000_0000);
    queue_item(CMD_GUST,   32'hFFFF_FFFF);
    queue_item(CMD_PULSE,  32'h0000_0100);
    queue_item(CMD_WINDOW, 32'h0000_0101);
    gen_now = 32'h0000_0101;
    wait_drained();   // sender pauses until every result is back

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin set_deb = 16'd0;     set_win = 16'd0;     end  // every check samples
        1: begin set_deb = 16'hFFFF;  set_win = 16'hFFFF;  end
        2: begin set_deb = 16'd10;    set_win = 16'd1;     end
        3: begin
          set_deb = 16'($urandom);
          set_win = 16'($urandom_range(1, 65535));
        end
        4: begin set_deb = 16'd3;     set_win = 16'd40;    end
        5: begin set_deb = 16'd1;     set_win = 16'd500;   end
        6: begin
          set_deb = 16'($urandom_range(0, 20));
          set_win = 16'($urandom_range(50, 2000));
        end
        default: begin set_deb = 16'd10; set_win = 16'd3000; end
      endcase
      write_reg(REG_DEBOUNCE, set_deb);
      write_reg(REG_WINDOW, set_win);
      send_idle_on = (p % 4 != 1);
      recv_idle_on = (p % 4 != 2);
      fill_phase(PHASE_ITEMS);
      if (p == 2 || p == 6) stall_req++;
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch("results never returned", results_due.size(), '0);
    if (fail_count == 0)
      $display("[anemometer_gust_meter] OK");
    else
      $display("[anemometer_gust_meter] ERROR");
    $finish;
  end

endmodule
